// File: rtl/sida_pkg.sv
// ---------------------------------------------------------------------------
// sida_pkg: shared types and constants for the integer-to-decimal converter
// Holds the field widths, ASCII codes, the controller/datapath command and
// status structs, and the four-bit shift-and-add-3 step used for BCD.
// ---------------------------------------------------------------------------
package sida_pkg;

	// Field widths.
	localparam int WordW  = 32;
	localparam int CharW  = 8;
	localparam int DigitN = 10;
	localparam int BcdW   = DigitN * 4;
	localparam int IdxW   = $clog2(DigitN);

	// Binary-to-BCD conversion takes four input bits per step.
	localparam int BitsPerStep = 4;
	localparam int StepN       = WordW / BitsPerStep;
	localparam int StepW       = $clog2(StepN);

	// ASCII codes.
	localparam logic [CharW-1:0] AsciiZero  = 8'd48;
	localparam logic [CharW-1:0] AsciiMinus = 8'd45;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input word and clear the BCD register
		logic step;       // shift four magnitude bits into the BCD register
		logic locate;     // find the most significant nonzero digit
		logic emit_sign;  // load a minus sign into the output register
		logic emit_digit; // load the current digit and move to the next one
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;        // the captured word is negative
		logic idx_zero;   // the current digit is the least significant one
	} sts_t;

	// Four rounds of shift-and-add-3, taking bits_in from its top bit down.
	function automatic logic [BcdW-1:0] dabble4(input logic [BcdW-1:0] bcd_in,
			input logic [BitsPerStep-1:0] bits_in);
		logic [BcdW-1:0] acc;
		acc = bcd_in;
		for (int r = 0; r < BitsPerStep; r++) begin
			for (int d = 0; d < DigitN; d++) begin
				if (acc[d*4 +: 4] >= 4'd5) begin
					acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
				end
			end
			acc = {acc[BcdW-2:0], bits_in[BitsPerStep-1-r]};
		end
		return acc;
	endfunction

endpackage

// File: rtl/sida_datapath.sv
// ---------------------------------------------------------------------------
// sida_datapath: magnitude, BCD and output registers
// Forms the magnitude of the input word, converts it to ten BCD digits four
// bits per step, locates the leading digit and loads output characters.
// ---------------------------------------------------------------------------
module sida_datapath (
	input  logic                        clk,
	input  sida_pkg::cmd_t              cmd,
	input  logic [sida_pkg::WordW-1:0]  value,
	output sida_pkg::sts_t              sts,
	output logic [sida_pkg::CharW-1:0]  character,
	output logic                        last
);
	import sida_pkg::*;

	logic [WordW-1:0] mag_q;
	logic [BcdW-1:0]  bcd_q;
	logic             neg_q;
	logic [IdxW-1:0]  idx_q;
	logic [CharW-1:0] char_q;
	logic             last_q;

	logic [WordW-1:0] mag_in;
	logic [IdxW-1:0]  lead_idx;
	logic [3:0]       cur_digit;

	// Magnitude in unsigned arithmetic, so the most negative word is exact.
	assign mag_in = value[WordW-1] ? (~value + WordW'(1)) : value;

	// Position of the most significant nonzero digit; zero maps to digit 0.
	always_comb begin
		lead_idx = '0;
		for (int d = 0; d < DigitN; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				lead_idx = IdxW'(d);
			end
		end
	end

	// Digit currently pointed at.
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

	// Conversion registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			neg_q <= value[WordW-1];
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[WordW-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
			bcd_q <= dabble4(bcd_q, mag_q[WordW-1 -: BitsPerStep]);
		end
	end

	// Digit pointer.
	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			idx_q <= lead_idx;
		end else if (cmd.emit_digit && idx_q != '0) begin
			idx_q <= idx_q - IdxW'(1);
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= AsciiMinus;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= AsciiZero + CharW'(cur_digit);
			last_q <= (idx_q == '0);
		end
	end

	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign character    = char_q;
	assign last         = last_q;

endmodule

// File: rtl/sida_ctrl.sv
// ---------------------------------------------------------------------------
// sida_ctrl: conversion sequencer
// Steps one word through capture, BCD conversion, leading digit search and
// character emission, and owns the handshakes of both channels.
// ---------------------------------------------------------------------------
module sida_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           value_valid,
	output logic           value_ready,
	output logic           text_valid,
	input  logic           text_ready,
	input  sida_pkg::sts_t sts,
	output sida_pkg::cmd_t cmd
);
	import sida_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_LOCATE = 3'd2;
	localparam logic [2:0] ST_SIGN   = 3'd3;
	localparam logic [2:0] ST_DIGIT  = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [StepW-1:0] step_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             accept;

	assign accept    = value_valid && value_ready;
	assign slot_free = !out_valid_q || text_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (step_q == StepW'(StepN - 1)) begin
					state_d = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				cmd.locate = 1'b1;
				state_d    = sts.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (slot_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV) begin
				step_q <= step_q + StepW'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (text_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign value_ready = (state_q == ST_IDLE);
	assign text_valid  = out_valid_q;

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Converts each input word to its decimal text, most significant character
// first, with a leading minus sign for negative values and last marked.
// ---------------------------------------------------------------------------
//
//  channel  signals                            word
//  -------  ---------------------------------  ---------------------------
//  value    value_valid, value_ready, value    one signed 32-bit integer
//  text     text_valid, text_ready,            one ASCII character and
//           character, last                    the end-of-number flag
//
// An input word is captured, converted to BCD four bits per cycle through the
// shift-and-add-3 unit and searched for its leading digit; then characters
// are loaded one per cycle while the text channel is not stalled. A stalled
// text channel holds the current character and pauses emission. The next word
// is accepted once the last character is loaded, while that character may
// still wait to be taken.
// Reset clears the controller and the output valid flag.
module signed_int_to_decimal_ascii (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        value_valid,
	output logic                        value_ready,
	input  logic [sida_pkg::WordW-1:0]  value,
	output logic                        text_valid,
	input  logic                        text_ready,
	output logic [sida_pkg::CharW-1:0]  character,
	output logic                        last
);
	import sida_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	sida_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Conversion and output registers.
	sida_datapath u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.character (character),
		.last      (last)
	);

endmodule

// File: rtl/sida_checker.sv
// ---------------------------------------------------------------------------
// sida_checker: port-level checks for the integer-to-decimal converter
// Watches the top-level ports and flags protocol and character-set slips.
// ---------------------------------------------------------------------------
module sida_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        value_valid,
	input logic                        value_ready,
	input logic                        text_valid,
	input logic                        text_ready,
	input logic [sida_pkg::CharW-1:0]  character,
	input logic                        last
);
	import sida_pkg::*;

	// A stalled output word holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(character) && $stable(last))
	else $error("output word changed while stalled");

	// Only a minus sign or a decimal digit is ever shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (character == AsciiMinus)
			|| (character >= AsciiZero && character <= AsciiZero + CharW'(9)))
	else $error("output character outside the decimal set");

	// A minus sign is never the final character of a number.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && character == AsciiMinus |-> !last)
	else $error("minus sign marked as last");

	// One word is converted at a time: the cycle after an input is taken,
	// no further input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_ready |=> !value_ready)
	else $error("input taken while a conversion is running");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.value_valid (value_valid),
	.value_ready (value_ready),
	.text_valid  (text_valid),
	.text_ready  (text_ready),
	.character   (character),
	.last        (last)
);
